### sv/pas_pkg.sv
// Shared types, constants and constant tables of the procedural ambience synth.
package pas_pkg;

    localparam int SAMPLE_RATE = 48000;
    localparam int PHASE_BITS  = 32;
    localparam int SIN_BITS    = 10;
    localparam int SIN_DEPTH   = 1 << SIN_BITS;
    localparam int TANH_BITS   = 10;
    localparam int TANH_DEPTH  = 1 << TANH_BITS;

    localparam longint unsigned Q30_ONE  = 64'd1 << 30;
    localparam longint unsigned Q30_HALF = 64'd1 << 29;
    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
    localparam longint unsigned SR_L = 64'(SAMPLE_RATE);

    // Phase increments from millihertz
    localparam logic [PHASE_BITS-1:0] INC_WATER_A =
        PHASE_BITS'(((64'd130 << PHASE_BITS) + SR_L * 500) / (SR_L * 1000));
    localparam logic [PHASE_BITS-1:0] INC_WATER_B =
        PHASE_BITS'(((64'd47 << PHASE_BITS) + SR_L * 500) / (SR_L * 1000));
    localparam logic [PHASE_BITS-1:0] INC_WIND_A =
        PHASE_BITS'(((64'd50 << PHASE_BITS) + SR_L * 500) / (SR_L * 1000));
    localparam logic [PHASE_BITS-1:0] INC_WIND_B =
        PHASE_BITS'(((64'd21 << PHASE_BITS) + SR_L * 500) / (SR_L * 1000));

    localparam logic signed [25:0] K_WALK_KEEP   = 26'sd1045430;
    localparam logic signed [25:0] K_WALK_IN     = 26'sd15729;
    localparam logic signed [25:0] K_WATER_LP    = 26'sd31457;
    localparam logic signed [25:0] K_WIND_LP     = 26'sd20972;
    localparam logic signed [25:0] K_WATER_BASE  = 26'sd629146;
    localparam logic signed [25:0] K_WATER_DEPTH = 26'sd419430;
    localparam logic signed [25:0] K_WIND_BASE   = 26'sd576717;
    localparam logic signed [25:0] K_WIND_DEPTH  = 26'sd471859;

    localparam logic [31:0] SEED_FALLBACK = 32'h9E37_79B9;
    localparam logic [15:0] BUS_GAIN_MAX  = 16'd32768;
    localparam logic [16:0] TARGET_MAX    = 17'd65536;

    // Configuration register indexes
    localparam logic [1:0] CFG_AMBIENT = 2'd0;
    localparam logic [1:0] CFG_MASTER  = 2'd1;
    localparam logic [1:0] CFG_SEED    = 2'd2;

    // Multiply steps
    localparam logic [3:0] M_W1 = 4'd0;
    localparam logic [3:0] M_W2 = 4'd1;
    localparam logic [3:0] M_W3 = 4'd2;
    localparam logic [3:0] M_D3 = 4'd3;
    localparam logic [3:0] M_C1 = 4'd4;
    localparam logic [3:0] M_C2 = 4'd5;
    localparam logic [3:0] M_C3 = 4'd6;
    localparam logic [3:0] M_C4 = 4'd7;
    localparam logic [3:0] M_C5 = 4'd8;
    localparam logic [3:0] M_F1 = 4'd9;
    localparam logic [3:0] M_F2 = 4'd10;

    typedef struct packed {
        logic       latch;
        logic       div_start;
        logic       set_ramp;
        logic       frame_init;
        logic       layer_begin;
        logic       sin_a;
        logic       sin_b;
        logic       mul;
        logic       post;
        logic       tanh0;
        logic       tanh1;
        logic       layer;
        logic [3:0] mstep;
    } cmd_t;

    typedef struct packed {
        logic kind;
        logic active;
        logic div_done;
        logic out_busy;
    } status_t;

    function automatic logic signed [21:0] sine_entry(input int i);
        longint unsigned k, r, s, x, x2, p, v;
        k  = (64'(i) * 4) / SIN_DEPTH;
        r  = 64'(i) * 4 - k * SIN_DEPTH;
        s  = k[0] ? SIN_DEPTH - r : r;
        x  = (PI_HALF_Q30 * s + SIN_DEPTH / 2) / SIN_DEPTH;
        x2 = (x * x + Q30_HALF) >> 30;
        p  = Q30_ONE;
        p  = Q30_ONE - ((x2 * p + Q30_HALF) >> 30) / 156;
        p  = Q30_ONE - ((x2 * p + Q30_HALF) >> 30) / 110;
        p  = Q30_ONE - ((x2 * p + Q30_HALF) >> 30) / 72;
        p  = Q30_ONE - ((x2 * p + Q30_HALF) >> 30) / 42;
        p  = Q30_ONE - ((x2 * p + Q30_HALF) >> 30) / 20;
        p  = Q30_ONE - ((x2 * p + Q30_HALF) >> 30) / 6;
        v  = (((x * p + Q30_HALF) >> 30) + 512) >> 10;
        if (v > 1048576) begin
            v = 1048576;
        end
        return (k >= 2) ? -22'(v) : 22'(v);
    endfunction

    // Long division for table building, one quotient bit per pass
    function automatic longint unsigned udiv_table(input longint unsigned num,
                                                   input longint unsigned den);
        longint unsigned q, r;
        q = 0;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            r = (r << 1) | ((num >> b) & 64'd1);
            if (r >= den) begin
                r = r - den;
                q = q | (64'd1 << b);
            end
        end
        return q;
    endfunction

    function automatic logic [15:0] tanh_entry(input int i);
        longint unsigned h, ratio, e, den, t;
        h = ((64'd16 << 30) + TANH_DEPTH / 2) / TANH_DEPTH;
        ratio = Q30_ONE;
        ratio = Q30_ONE - ((h * ratio + Q30_HALF) >> 30) / 6;
        ratio = Q30_ONE - ((h * ratio + Q30_HALF) >> 30) / 5;
        ratio = Q30_ONE - ((h * ratio + Q30_HALF) >> 30) / 4;
        ratio = Q30_ONE - ((h * ratio + Q30_HALF) >> 30) / 3;
        ratio = Q30_ONE - ((h * ratio + Q30_HALF) >> 30) / 2;
        ratio = Q30_ONE - ((h * ratio + Q30_HALF) >> 30);
        e = Q30_ONE;
        for (int j = 0; j < i; j++) begin
            e = (e * ratio + Q30_HALF) >> 30;
        end
        den = Q30_ONE + e;
        t = udiv_table((Q30_ONE - e) * 65536 + den, den << 1);
        if (t > 32767) begin
            t = 32767;
        end
        return 16'(t);
    endfunction

endpackage

### sv/pas_div.sv
// Restoring divider for the gain ramp step, one quotient bit per cycle.
module pas_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [16:0] dividend,
    input  logic [19:0] divisor,
    output logic        done,
    output logic [16:0] quotient
);

    logic [19:0] rem_reg;
    logic [16:0] quo_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [20:0] trial;

    assign trial = {rem_reg, quo_reg[16]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd17;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            if (trial >= {1'b0, divisor}) begin
                rem_reg <= 20'(trial - {1'b0, divisor});
                quo_reg <= {quo_reg[15:0], 1'b1};
            end else begin
                rem_reg <= trial[19:0];
                quo_reg <= {quo_reg[15:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### sv/pas_dp.sv
// Datapath: layer state, shared multiplier, sine and tanh tables, output register.
module pas_dp (
    input  logic               aclk,
    input  logic               aresetn,
    input  pas_pkg::cmd_t      cmd,
    output pas_pkg::status_t   st,
    input  logic               in_kind,
    input  logic               in_layer,
    input  logic [16:0]        in_target_gain,
    input  logic [19:0]        in_ramp_samples,
    input  logic [15:0]        amb_gain,
    input  logic [15:0]        mst_gain,
    input  logic               seed_load,
    input  logic [31:0]        seed,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_mix_sample
);

    localparam int TIDX_W = pas_pkg::TANH_BITS + 1;
    localparam int FRAC_SH = 23 - pas_pkg::TANH_BITS;

    logic signed [21:0] sine_rom [pas_pkg::SIN_DEPTH];
    logic        [15:0] tanh_rom [pas_pkg::TANH_DEPTH + 1];

    for (genvar gi = 0; gi < pas_pkg::SIN_DEPTH; gi++) begin : g_sin
        assign sine_rom[gi] = pas_pkg::sine_entry(gi);
    end
    for (genvar gi = 0; gi <= pas_pkg::TANH_DEPTH; gi++) begin : g_tanh
        assign tanh_rom[gi] = pas_pkg::tanh_entry(gi);
    end

    // latched item
    logic        kind_reg;
    logic        layer_in_reg;
    logic [16:0] tg_reg;
    logic [19:0] rs_reg;

    // block state
    logic [31:0]                      noise_reg;
    logic signed [23:0]               brown_reg;
    logic signed [23:0]               lp_reg    [2];
    logic [pas_pkg::PHASE_BITS-1:0]   pha_reg   [2];
    logic [pas_pkg::PHASE_BITS-1:0]   phb_reg   [2];
    logic [16:0]                      gain_reg  [2];
    logic [16:0]                      tgt_reg   [2];
    logic signed [17:0]               step_reg  [2];

    // working registers
    logic signed [20:0] n_reg;
    logic signed [21:0] sin_a_reg;
    logic signed [21:0] sin_b_reg;
    logic signed [24:0] tmp_reg;
    logic signed [23:0] sum_reg;
    logic signed [51:0] prod_reg;
    logic [TIDX_W-1:0]  tidx_reg;
    logic [22:0]        frac_reg;
    logic               neg_reg;
    logic [15:0]        t0_reg;
    logic [15:0]        t1_reg;
    logic               mv_reg;
    logic signed [15:0] mix_reg;

    logic               lsel;
    logic signed [25:0] mul_a;
    logic signed [25:0] mul_b;
    logic signed [35:0] q20;
    logic signed [35:0] q16;
    logic signed [35:0] q14;
    logic signed [35:0] q23;
    logic signed [17:0] diff;
    logic [16:0]        diff_mag;
    logic               div_done;
    logic [16:0]        quo;
    logic signed [17:0] step_new;
    logic [31:0]        nx;
    logic signed [18:0] g_sum;
    logic               arrived;
    logic signed [39:0] q20x;
    logic signed [23:0] m_sat;
    logic signed [24:0] m_abs;
    logic [22:0]        a_clamp;
    logic signed [17:0] y;
    logic signed [25:0] base_k;
    logic signed [25:0] depth_k;

    function automatic logic signed [35:0] rnd(input logic signed [51:0] p, input int sh);
        logic signed [52:0] t;
        t = 53'(p) + (53'sd1 <<< (sh - 1));
        return 36'(t >>> sh);
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [39:0] v);
        if (v > 40'sd8388607) begin
            return 24'sd8388607;
        end
        if (v < -40'sd8388608) begin
            return -24'sd8388608;
        end
        return 24'(v);
    endfunction

    assign lsel = kind_reg ? layer_in_reg : cmd.layer;

    assign st.kind     = kind_reg;
    assign st.active   = (gain_reg[lsel] != '0) || (tgt_reg[lsel] != '0) ||
                         (step_reg[lsel] != '0);
    assign st.div_done = div_done;
    assign st.out_busy = mv_reg && !m_ready;

    // gain ramp setup
    assign diff     = $signed({1'b0, tg_reg}) - $signed({1'b0, gain_reg[lsel]});
    assign diff_mag = diff[17] ? 17'(-diff) : 17'(diff);

    pas_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (diff_mag),
        .divisor  (rs_reg),
        .done     (div_done),
        .quotient (quo)
    );

    always_comb begin
        if (rs_reg == '0) begin
            step_new = diff;
        end else if (quo == '0 && diff != '0) begin
            step_new = diff[17] ? -18'sd1 : 18'sd1;
        end else begin
            step_new = diff[17] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
        end
    end

    // xorshift32 draw
    always_comb begin
        nx = noise_reg;
        nx = nx ^ (nx << 13);
        nx = nx ^ (nx >> 17);
        nx = nx ^ (nx << 5);
    end

    assign g_sum   = 19'($signed({1'b0, gain_reg[lsel]})) + 19'(step_reg[lsel]);
    assign arrived = step_reg[lsel][17] ? (g_sum <= $signed({2'b0, tgt_reg[lsel]}))
                                        : (g_sum >= $signed({2'b0, tgt_reg[lsel]}));

    assign base_k  = lsel ? pas_pkg::K_WIND_BASE  : pas_pkg::K_WATER_BASE;
    assign depth_k = lsel ? pas_pkg::K_WIND_DEPTH : pas_pkg::K_WATER_DEPTH;

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mstep)
            pas_pkg::M_W1: begin
                mul_a = 26'(brown_reg);
                mul_b = pas_pkg::K_WALK_KEEP;
            end
            pas_pkg::M_W2: begin
                mul_a = pas_pkg::K_WALK_IN;
                mul_b = 26'(n_reg);
            end
            pas_pkg::M_W3: begin
                mul_a = pas_pkg::K_WATER_LP;
                mul_b = 26'(brown_reg) - 26'(lp_reg[lsel]);
            end
            pas_pkg::M_D3: begin
                mul_a = pas_pkg::K_WIND_LP;
                mul_b = 26'(n_reg) - 26'(lp_reg[lsel]);
            end
            pas_pkg::M_C1: begin
                mul_a = 26'(sin_a_reg);
                mul_b = 26'(sin_b_reg);
            end
            pas_pkg::M_C2: begin
                mul_a = depth_k;
                mul_b = 26'(tmp_reg);
            end
            pas_pkg::M_C3: begin
                mul_a = 26'(lp_reg[lsel]);
                mul_b = 26'(tmp_reg);
            end
            pas_pkg::M_C4: begin
                mul_a = 26'(tmp_reg);
                mul_b = $signed({9'b0, gain_reg[lsel]});
            end
            pas_pkg::M_C5: begin
                mul_a = 26'(tmp_reg);
                mul_b = $signed({10'b0, amb_gain});
            end
            pas_pkg::M_F1: begin
                mul_a = 26'(sum_reg);
                mul_b = $signed({10'b0, mst_gain});
            end
            pas_pkg::M_F2: begin
                mul_a = 26'($signed({1'b0, t1_reg}) - $signed({1'b0, t0_reg}));
                mul_b = $signed({3'b0, frac_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign q20  = rnd(prod_reg, 20);
    assign q16  = rnd(prod_reg, 16);
    assign q14  = rnd(prod_reg, 14);
    assign q23  = rnd(prod_reg, 23);
    assign q20x = 40'(q20);

    assign m_sat   = sat24(40'(q14));
    assign m_abs   = m_sat[23] ? -25'(m_sat) : 25'(m_sat);
    assign a_clamp = (m_abs > 25'sd8388607) ? 23'h7F_FFFF : 23'(m_abs);
    assign y       = 18'($signed({1'b0, t0_reg})) + 18'(q23);

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            kind_reg     <= in_kind;
            layer_in_reg <= in_layer;
            tg_reg       <= (in_target_gain > pas_pkg::TARGET_MAX) ? pas_pkg::TARGET_MAX
                                                                   : in_target_gain;
            rs_reg       <= in_ramp_samples;
        end
        if (cmd.mul) begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.layer_begin) begin
            n_reg <= $signed(nx[31:11]);
        end
        if (cmd.sin_a) begin
            sin_a_reg <= sine_rom[pha_reg[lsel][pas_pkg::PHASE_BITS-1 -: pas_pkg::SIN_BITS]];
        end
        if (cmd.sin_b) begin
            sin_b_reg <= sine_rom[phb_reg[lsel][pas_pkg::PHASE_BITS-1 -: pas_pkg::SIN_BITS]];
        end
        if (cmd.tanh0) begin
            t0_reg <= tanh_rom[tidx_reg];
        end
        if (cmd.tanh1) begin
            t1_reg <= tanh_rom[TIDX_W'(tidx_reg + 1'b1)];
        end
        if (cmd.post) begin
            case (cmd.mstep)
                pas_pkg::M_W1: tmp_reg <= 25'(q20);
                pas_pkg::M_C1: tmp_reg <= 25'(q20);
                pas_pkg::M_C2: tmp_reg <= 25'(40'(base_k) + q20x);
                pas_pkg::M_C3: tmp_reg <= 25'(sat24(lsel ? (q20x <<< 2) + (q20x <<< 1)
                                                           : (q20x <<< 2) + q20x));
                pas_pkg::M_C4: tmp_reg <= 25'(sat24(40'(q16)));
                pas_pkg::M_F1: begin
                    neg_reg  <= m_sat[23];
                    tidx_reg <= TIDX_W'(a_clamp[22 -: pas_pkg::TANH_BITS]);
                    frac_reg <= {a_clamp[FRAC_SH-1:0], pas_pkg::TANH_BITS'(0)};
                end
                pas_pkg::M_F2: mix_reg <= neg_reg ? 16'(-y) : 16'(y);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            noise_reg <= pas_pkg::SEED_FALLBACK;
            brown_reg <= '0;
            sum_reg   <= '0;
            mv_reg    <= 1'b0;
            for (int l = 0; l < 2; l++) begin
                lp_reg[l]   <= '0;
                pha_reg[l]  <= '0;
                phb_reg[l]  <= '0;
                gain_reg[l] <= '0;
                tgt_reg[l]  <= '0;
                step_reg[l] <= '0;
            end
        end else begin
            if (seed_load) begin
                noise_reg <= (seed == '0) ? pas_pkg::SEED_FALLBACK : seed;
            end else if (cmd.layer_begin) begin
                noise_reg <= nx;
            end
            if (cmd.set_ramp) begin
                tgt_reg[lsel]  <= tg_reg;
                step_reg[lsel] <= step_new;
            end
            if (cmd.layer_begin) begin
                if (step_reg[lsel] != '0) begin
                    if (arrived) begin
                        gain_reg[lsel] <= tgt_reg[lsel];
                        step_reg[lsel] <= '0;
                    end else begin
                        gain_reg[lsel] <= 17'(g_sum);
                    end
                end
                pha_reg[lsel] <= pha_reg[lsel] + (lsel ? pas_pkg::INC_WIND_A
                                                       : pas_pkg::INC_WATER_A);
                phb_reg[lsel] <= phb_reg[lsel] + (lsel ? pas_pkg::INC_WIND_B
                                                       : pas_pkg::INC_WATER_B);
            end
            if (cmd.frame_init) begin
                sum_reg <= '0;
            end
            if (cmd.post) begin
                case (cmd.mstep)
                    pas_pkg::M_W2: brown_reg <= sat24(40'(tmp_reg) + q20x);
                    pas_pkg::M_W3: lp_reg[lsel] <= sat24(40'(lp_reg[lsel]) + q20x);
                    pas_pkg::M_D3: lp_reg[lsel] <= sat24(40'(lp_reg[lsel]) + q20x);
                    pas_pkg::M_C5: sum_reg <= sat24(40'(sum_reg) + 40'(sat24(40'(q14))));
                    default: ;
                endcase
            end
            if (cmd.post && cmd.mstep == pas_pkg::M_F2) begin
                mv_reg <= 1'b1;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    assign m_valid      = mv_reg;
    assign m_mix_sample = mix_reg;

endmodule

### sv/pas_ctrl.sv
// Controller: sequences item dispatch, the divider and the multiply steps of a frame.
module pas_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  pas_pkg::status_t st,
    output pas_pkg::cmd_t    cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_DIV      = 4'd2;
    localparam logic [3:0] S_LCHECK   = 4'd3;
    localparam logic [3:0] S_LBEGIN   = 4'd4;
    localparam logic [3:0] S_SINA     = 4'd5;
    localparam logic [3:0] S_SINB     = 4'd6;
    localparam logic [3:0] S_MUL      = 4'd7;
    localparam logic [3:0] S_POST     = 4'd8;
    localparam logic [3:0] S_TANH0    = 4'd9;
    localparam logic [3:0] S_TANH1    = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       layer_reg, layer_next;
    logic [3:0] mstep_reg, mstep_next;

    always_comb begin
        state_next = state_reg;
        layer_next = layer_reg;
        mstep_next = mstep_reg;
        cmd        = '0;
        cmd.layer  = layer_reg;
        cmd.mstep  = mstep_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (st.kind) begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end else begin
                    cmd.frame_init = 1'b1;
                    layer_next     = 1'b0;
                    state_next     = S_LCHECK;
                end
            end
            S_DIV: begin
                if (st.div_done) begin
                    cmd.set_ramp = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_LCHECK: begin
                if (st.active) begin
                    state_next = S_LBEGIN;
                end else if (layer_reg) begin
                    mstep_next = pas_pkg::M_F1;
                    state_next = S_MUL;
                end else begin
                    layer_next = 1'b1;
                end
            end
            S_LBEGIN: begin
                cmd.layer_begin = 1'b1;
                mstep_next      = layer_reg ? pas_pkg::M_D3 : pas_pkg::M_W1;
                state_next      = S_SINA;
            end
            S_SINA: begin
                cmd.sin_a  = 1'b1;
                state_next = S_SINB;
            end
            S_SINB: begin
                cmd.sin_b  = 1'b1;
                state_next = S_MUL;
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_POST;
            end
            S_POST: begin
                if (!(mstep_reg == pas_pkg::M_F2 && st.out_busy)) begin
                    cmd.post   = 1'b1;
                    state_next = S_MUL;
                    unique case (mstep_reg)
                        pas_pkg::M_W1: mstep_next = pas_pkg::M_W2;
                        pas_pkg::M_W2: mstep_next = pas_pkg::M_W3;
                        pas_pkg::M_W3: mstep_next = pas_pkg::M_C1;
                        pas_pkg::M_D3: mstep_next = pas_pkg::M_C1;
                        pas_pkg::M_C1: mstep_next = pas_pkg::M_C2;
                        pas_pkg::M_C2: mstep_next = pas_pkg::M_C3;
                        pas_pkg::M_C3: mstep_next = pas_pkg::M_C4;
                        pas_pkg::M_C4: mstep_next = pas_pkg::M_C5;
                        pas_pkg::M_C5: begin
                            if (layer_reg) begin
                                mstep_next = pas_pkg::M_F1;
                            end else begin
                                layer_next = 1'b1;
                                state_next = S_LCHECK;
                            end
                        end
                        pas_pkg::M_F1: state_next = S_TANH0;
                        default:       state_next = S_IDLE;
                    endcase
                end
            end
            S_TANH0: begin
                cmd.tanh0  = 1'b1;
                state_next = S_TANH1;
            end
            S_TANH1: begin
                cmd.tanh1  = 1'b1;
                mstep_next = pas_pkg::M_F2;
                state_next = S_MUL;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            layer_reg <= 1'b0;
            mstep_reg <= pas_pkg::M_W1;
        end else begin
            state_reg <= state_next;
            layer_reg <= layer_next;
            mstep_reg <= mstep_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    a_out_not_overwritten: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.post && cmd.mstep == pas_pkg::M_F2) |-> !st.out_busy)
        else $error("result loaded over a beat not yet taken");

    a_accept_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> state_reg == S_DISPATCH)
        else $error("accepted beat not dispatched");

    a_div_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV && st.div_done) |=> state_reg == S_IDLE)
        else $error("ramp setup did not return to idle");

endmodule

### sv/procedural_ambience_synth.sv
// Top level of the procedural ambience synth: configuration registers and core wiring.
//
// Two procedural layers (water: leaky random walk into a one-pole lowpass; wind:
// lowpassed white noise) share one xorshift32 source, are shaped by a two-sine swell,
// ramped by per-layer gains, scaled by the ambient bus gain, summed, scaled by the
// master gain and soft-clipped through a tanh table into a Q1.15 sample. Items are
// handled one at a time. A render item (kind 0) puts its result on m_valid whether
// none, one or both layers are active. The single shared 26x26 multiplier serves each
// step of the chain in turn. A gain item (kind 1) waits on the bit-serial divider that
// forms the ramp step. The next item is taken as soon as the core is back in idle, even
// while the last sample still waits on m_ready. Configuration writes are always ready;
// write them only while the block is idle. The sine and tanh tables are constant, so
// no clearing pass follows reset.
module procedural_ambience_synth (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_kind,
    input  logic               s_layer,
    input  logic [16:0]        s_target_gain,
    input  logic [19:0]        s_ramp_samples,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_mix_sample,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    pas_pkg::cmd_t    cmd;
    pas_pkg::status_t st;

    logic [15:0] amb_reg;
    logic [15:0] mst_reg;
    logic [15:0] v16;
    logic        cfg_we;
    logic        seed_load;

    // Clamp gain writes to 2.0 in Q2.14
    assign v16       = (cfg_data[15:0] > pas_pkg::BUS_GAIN_MAX) ? pas_pkg::BUS_GAIN_MAX
                                                                : cfg_data[15:0];
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    // A seed beat reloads the noise generator directly
    assign seed_load = cfg_we && (cfg_index == pas_pkg::CFG_SEED);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            amb_reg <= 16'd16384;
            mst_reg <= 16'd16384;
        end else if (cfg_we) begin
            unique case (cfg_index)
                pas_pkg::CFG_AMBIENT: amb_reg <= v16;
                pas_pkg::CFG_MASTER:  mst_reg <= v16;
                default: ;
            endcase
        end
    end

    pas_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    pas_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .st              (st),
        .in_kind         (s_kind),
        .in_layer        (s_layer),
        .in_target_gain  (s_target_gain),
        .in_ramp_samples (s_ramp_samples),
        .amb_gain        (amb_reg),
        .mst_gain        (mst_reg),
        .seed_load       (seed_load),
        .seed            (cfg_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_mix_sample    (m_mix_sample)
    );

endmodule
